/* rtl/core/ctgr_pkg.sv */
// Package for the centred text glyph renderer: command codes, microcode
// control word, datapath control and status types, and the 5x7 font table.
// No dependencies; imported by every module of the block.
package ctgr_pkg;

  // Default geometry of the frame store
  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 8;

  // Longest line taken into account for centring
  localparam int MAX_LINE_CHARS = 64;

  // Font geometry
  localparam int GLYPH_FIRST = 32;
  localparam int GLYPH_LAST  = 126;
  localparam int GLYPH_COUNT = GLYPH_LAST - GLYPH_FIRST + 1;
  localparam int GLYPH_WIDTH = 5;
  localparam int CELL_WIDTH  = 6;
  localparam int GLYPH_BITS  = 8 * GLYPH_WIDTH;
  localparam int GLYPH_IDX_W = 7;

  // Field widths of one command
  localparam int CMD_W   = 2;
  localparam int PAGE_W  = 3;
  localparam int LEN_W   = 6;
  localparam int POS_W   = 6;
  localparam int CODE_W  = 8;
  localparam int RADDR_W = 10;
  localparam int DATA_W  = 8;

  // Signed column width: covers the start column over the whole geometry range
  localparam int START_W = 11;
  localparam int T3_W    = 8;   // 3 * line length
  localparam int P6_W    = 9;   // 6 * position
  localparam int CELL_CNT_W = 3;

  typedef logic [GLYPH_BITS-1:0] glyph_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Datapath operation selected by the current microcode step
  typedef enum logic [2:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_SETUP_A,
    DP_SETUP_B,
    DP_SETUP_C,
    DP_COLUMN,
    DP_READ,
    DP_RESULT
  } dp_op_e;

  // Sequencing of the step counter
  typedef enum logic [2:0] {
    J_NEXT,
    J_DISPATCH,
    J_UNTIL_LAST,
    J_IF_BAD_PAGE,
    J_ALWAYS
  } jump_e;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram addresses
  localparam upc_t U_IDLE    = 3'd0;
  localparam upc_t U_CLEAR   = 3'd1;
  localparam upc_t U_SETUP_A = 3'd2;
  localparam upc_t U_SETUP_B = 3'd3;
  localparam upc_t U_SETUP_C = 3'd4;
  localparam upc_t U_COLUMN  = 3'd5;
  localparam upc_t U_READ    = 3'd6;
  localparam upc_t U_RESULT  = 3'd7;

  typedef struct packed {
    logic   busy;
    dp_op_e op;
    jump_e  jmp;
    upc_t   tgt;
  } cw_t;

  typedef struct packed {
    dp_op_e op;
    logic   load;
  } dp_ctl_t;

  typedef struct packed {
    logic last;
    logic page_bad;
  } dp_stat_t;

  // Control store: one word per step
  function automatic cw_t ucode(upc_t upc);
    cw_t cw;
    unique case (upc)
      U_IDLE:    cw = '{busy: 1'b0, op: DP_IDLE,    jmp: J_DISPATCH,    tgt: U_IDLE};
      U_CLEAR:   cw = '{busy: 1'b1, op: DP_CLEAR,   jmp: J_UNTIL_LAST,  tgt: U_IDLE};
      U_SETUP_A: cw = '{busy: 1'b1, op: DP_SETUP_A, jmp: J_IF_BAD_PAGE, tgt: U_IDLE};
      U_SETUP_B: cw = '{busy: 1'b1, op: DP_SETUP_B, jmp: J_NEXT,        tgt: U_IDLE};
      U_SETUP_C: cw = '{busy: 1'b1, op: DP_SETUP_C, jmp: J_NEXT,        tgt: U_IDLE};
      U_COLUMN:  cw = '{busy: 1'b1, op: DP_COLUMN,  jmp: J_UNTIL_LAST,  tgt: U_IDLE};
      U_READ:    cw = '{busy: 1'b1, op: DP_READ,    jmp: J_NEXT,        tgt: U_IDLE};
      U_RESULT:  cw = '{busy: 1'b1, op: DP_RESULT,  jmp: J_ALWAYS,      tgt: U_IDLE};
      default:   cw = '{busy: 1'b1, op: DP_IDLE,    jmp: J_ALWAYS,      tgt: U_IDLE};
    endcase
    return cw;
  endfunction

  // 5x7 font, codes 32..126; leftmost column in the top byte, bit 0 is the top row
  localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

endpackage

/* rtl/core/ctgr_fstore.sv */
// Frame store: single-port byte memory, one write or one read per cycle.
// Depends on ctgr_pkg for the data width.
module ctgr_fstore
  import ctgr_pkg::*;
#(
  parameter int DEPTH = DEF_PAGES * DEF_COLUMNS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ctgr_useq.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on ctgr_pkg for the control word, jump codes and step addresses.
module ctgr_useq
  import ctgr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CMD_W-1:0] command_i,
  input  dp_stat_t         stat_i,
  output dp_ctl_t          ctl_o,
  output logic             busy
);

  upc_t upc_q, upc_d;
  cw_t  cw;

  assign cw = ucode(upc_q);

  // Drive the datapath from the current control word
  always_comb begin
    ctl_o.op   = cw.op;
    ctl_o.load = (cw.jmp == J_DISPATCH) && start;
  end

  assign busy = cw.busy;

  // Select the next step
  always_comb begin
    upc_d = upc_q;
    unique case (cw.jmp)
      J_NEXT:        upc_d = upc_q + upc_t'(1);
      J_DISPATCH: begin
        if (start) begin
          case (cmd_e'(command_i))
            CMD_CLEAR: upc_d = U_CLEAR;
            CMD_DRAW:  upc_d = U_SETUP_A;
            CMD_READ:  upc_d = U_READ;
            default:   upc_d = U_IDLE;
          endcase
        end
      end
      J_UNTIL_LAST:  upc_d = stat_i.last ? cw.tgt : upc_q;
      J_IF_BAD_PAGE: upc_d = stat_i.page_bad ? cw.tgt : upc_q + upc_t'(1);
      J_ALWAYS:      upc_d = cw.tgt;
      default:       upc_d = U_IDLE;
    endcase
  end

  // Step counter; reset enters the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

/* rtl/core/ctgr_dpath.sv */
// Datapath: command latch, centring arithmetic, glyph shifter, clear counter
// and result register. Depends on ctgr_pkg; drives the ctgr_fstore port.
module ctgr_dpath
  import ctgr_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int PAGES   = DEF_PAGES,
  parameter int DEPTH   = PAGES * COLUMNS,
  parameter int AW      = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_ctl_t            ctl_i,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic [LEN_W-1:0]   line_length_i,
  input  logic [POS_W-1:0]   char_position_i,
  input  logic [CODE_W-1:0]  char_code_i,
  input  logic [RADDR_W-1:0] read_address_i,
  output dp_stat_t           stat_o,
  output logic               mem_we_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_addr_o,
  output logic [DATA_W-1:0]  mem_wdata_o,
  input  logic [DATA_W-1:0]  mem_rdata_i,
  output logic               result_strobe_o,
  output logic [DATA_W-1:0]  read_data_o
);

  localparam logic [AW-1:0]               LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic signed [START_W-1:0]   FLOOR_HALF = START_W'(COLUMNS / 2);
  localparam logic signed [START_W-1:0]   CEIL_HALF  = START_W'((COLUMNS + 1) / 2);
  localparam logic signed [START_W-1:0]   COLS_S     = START_W'(COLUMNS);
  localparam bit                          COLS_ODD   = (COLUMNS % 2) == 1;
  localparam logic [CELL_CNT_W-1:0]       K_LAST     = CELL_CNT_W'(CELL_WIDTH - 1);

  // Latched command fields
  logic [PAGE_W-1:0]  page_q;
  logic [LEN_W-1:0]   len_q;
  logic [POS_W-1:0]   pos_q;
  logic [CODE_W-1:0]  code_q;
  logic [RADDR_W-1:0] raddr_q;

  // Working registers
  logic [T3_W-1:0]             t3_q;
  logic [P6_W-1:0]             p6_q;
  logic [AW-1:0]               base_q;
  glyph_t                      glyph_q;
  logic signed [START_W-1:0]   col_q;
  logic [CELL_CNT_W-1:0]       k_q;
  logic [AW-1:0]               clr_q;
  logic                        strobe_q;
  logic [DATA_W-1:0]           data_q;

  logic [LEN_W-1:0]            len_sat;
  logic [POS_W-1:0]            pos_sat;
  logic                        code_ok;
  logic [GLYPH_IDX_W-1:0]      glyph_idx;
  logic signed [START_W-1:0]   t3_s;
  logic signed [START_W-1:0]   cent;
  logic                        col_ok;
  logic                        raddr_ok;
  logic [AW+RADDR_W-1:0]       raddr_ext;

  // Saturate line length and position, map unprintable codes to space
  always_comb begin
    len_sat = (int'(len_q) > MAX_LINE_CHARS) ? LEN_W'(MAX_LINE_CHARS) : len_q;
    pos_sat = (int'(pos_q) > MAX_LINE_CHARS - 1) ? POS_W'(MAX_LINE_CHARS - 1) : pos_q;
    code_ok = (int'(code_q) >= GLYPH_FIRST) && (int'(code_q) <= GLYPH_LAST);
    glyph_idx = code_ok ? GLYPH_IDX_W'(code_q - CODE_W'(GLYPH_FIRST)) : '0;
  end

  // Half of (COLUMNS - 6*len), truncated toward zero
  always_comb begin
    t3_s = START_W'(t3_q);
    if (COLS_ODD && (int'(t3_q) > COLUMNS / 2)) begin
      cent = CEIL_HALF - t3_s;
    end else begin
      cent = FLOOR_HALF - t3_s;
    end
  end

  assign col_ok    = !col_q[START_W-1] && (col_q < COLS_S);
  assign raddr_ok  = int'(raddr_q) < DEPTH;
  assign raddr_ext = {{AW{1'b0}}, raddr_q};

  // Status back to the sequencer
  always_comb begin
    stat_o.page_bad = int'(page_q) >= PAGES;
    stat_o.last     = (ctl_i.op == DP_CLEAR) ? (clr_q == LAST_ADDR) : (k_q == K_LAST);
  end

  // Memory port
  always_comb begin
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = clr_q;
    mem_wdata_o = '0;
    case (ctl_i.op)
      DP_CLEAR: begin
        mem_we_o = 1'b1;
      end
      DP_COLUMN: begin
        mem_we_o    = col_ok;
        mem_addr_o  = base_q + AW'(col_q);
        mem_wdata_o = glyph_q[GLYPH_BITS-1 -: DATA_W];
      end
      DP_READ: begin
        mem_re_o   = 1'b1;
        mem_addr_o = raddr_ext[AW-1:0];
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  // Hold the command fields of an accepted transfer
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      page_q  <= page_i;
      len_q   <= line_length_i;
      pos_q   <= char_position_i;
      code_q  <= char_code_i;
      raddr_q <= read_address_i;
    end
  end

  // Centring arithmetic and glyph shifter
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      DP_SETUP_A: begin
        t3_q    <= T3_W'(len_sat) * T3_W'(3);
        p6_q    <= P6_W'(pos_sat) * P6_W'(CELL_WIDTH);
        base_q  <= AW'(int'(page_q) * COLUMNS);
        glyph_q <= GLYPH_ROM[glyph_idx];
      end
      DP_SETUP_B: begin
        col_q <= cent;
      end
      DP_SETUP_C: begin
        col_q <= col_q + START_W'(p6_q);
      end
      DP_COLUMN: begin
        col_q   <= col_q + START_W'(1);
        glyph_q <= glyph_q << DATA_W;
      end
      default: begin
        col_q <= col_q;
      end
    endcase
  end

  // Column count within the cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (ctl_i.op == DP_SETUP_C) begin
      k_q <= '0;
    end else if (ctl_i.op == DP_COLUMN) begin
      k_q <= k_q + CELL_CNT_W'(1);
    end
  end

  // Clear sweep address; wraps to zero after the last entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.op == DP_CLEAR) begin
      clr_q <= stat_o.last ? '0 : clr_q + AW'(1);
    end
  end

  // Result strobe, one cycle per read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (ctl_i.op == DP_RESULT);
    end
  end

  // Result byte; addresses beyond the store read as zero
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_RESULT) begin
      data_q <= raddr_ok ? mem_rdata_i : '0;
    end
  end

  assign result_strobe_o = strobe_q;
  assign read_data_o     = data_q;

endmodule

/* rtl/core/centered_text_glyph_renderer_top.sv */
// Top level of the centred text glyph renderer: microcode sequencer,
// datapath and frame store. Depends on ctgr_pkg, ctgr_useq, ctgr_dpath, ctgr_fstore.
//
//   channel   direction  handshake                  payload
//   command   in         start & !busy              command_i, page_i, line_length_i,
//                                                   char_position_i, char_code_i,
//                                                   read_address_i
//   result    out        result_strobe_o (1 cycle)  read_data_o
//
// A draw keeps busy high after its transfer for three set-up steps, then six column
// writes through the single memory port; a new draw is taken only once it is done.
// A draw to a page beyond the store ends after one step. A read passes a read step
// and a result step, then strobes its byte. A clear, and the sweep after reset, writes
// one byte per cycle to all PAGES*COLUMNS bytes (1024 by default) with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module centered_text_glyph_renderer_top
  import ctgr_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int PAGES   = DEF_PAGES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic [LEN_W-1:0]   line_length_i,
  input  logic [POS_W-1:0]   char_position_i,
  input  logic [CODE_W-1:0]  char_code_i,
  input  logic [RADDR_W-1:0] read_address_i,
  output logic               result_strobe_o,
  output logic [DATA_W-1:0]  read_data_o
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  dp_ctl_t           ctl;
  dp_stat_t          stat;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  // Step through the microprogram
  ctgr_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .busy      (busy)
  );

  // Execute the selected operation
  ctgr_dpath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .page_i          (page_i),
    .line_length_i   (line_length_i),
    .char_position_i (char_position_i),
    .char_code_i     (char_code_i),
    .read_address_i  (read_address_i),
    .stat_o          (stat),
    .mem_we_o        (mem_we),
    .mem_re_o        (mem_re),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata),
    .result_strobe_o (result_strobe_o),
    .read_data_o     (read_data_o)
  );

  // Hold the frame
  ctgr_fstore #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_fstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTH
  // A result only follows the result step of a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(ctl.op == DP_RESULT))
    else $error("result strobe without a read");

  // Every accepted read produces its strobe after its read and result steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_READ) |-> ##3 result_strobe_o)
    else $error("read result missing");

  // Strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe held for two cycles");

  // The store is never written while the block reports idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !mem_we)
    else $error("frame store written while idle");
`endif

endmodule
